@@ sv/token_bucket_rate_limiter_defines.svh @@
// Assertion macros for the token bucket rate limiter.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef TOKEN_BUCKET_RATE_LIMITER_DEFINES_SVH
`define TOKEN_BUCKET_RATE_LIMITER_DEFINES_SVH

// Checked at every rising edge outside reset.
`define TBRL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define TBRL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/tbrl_pkg.sv @@
// Shared constants, types and helpers for the token bucket rate limiter.
// No dependencies.
package tbrl_pkg;

	// Nanoseconds in one second; the refill divisor.
	localparam logic [63:0] NS_PER_SEC = 64'd1000000000;

	// Reciprocal of the refill divisor, floor(2^61 / 1e9). The quotient that it gives
	// falls short of the true one by at most four.
	localparam logic [31:0] NS_RECIP = 32'd2305843009;

	// Counter saturation limit, capped at the 32-bit state width.
	localparam int COUNT_WIDTH = 32;
	localparam logic [31:0] CNT_MAX = (COUNT_WIDTH >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << COUNT_WIDTH) - 64'd1);

	// Configuration register indexes.
	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_RATE     = 2'd1;
	localparam logic [1:0] REG_START    = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [31:0] CAPACITY_RST = 32'd65536;
	localparam logic [31:0] RATE_RST     = 32'd65536;
	localparam logic [63:0] START_RST    = 64'd0;

	// One result item.
	typedef struct packed {
		logic [31:0] rejected_total;
		logic [31:0] accepted_total;
		logic [31:0] tokens_left;
		logic        allowed;
	} result_t;

	// Saturating increment of an event counter.
	function automatic logic [31:0] count_up(input logic [31:0] c);
		count_up = (c >= CNT_MAX) ? CNT_MAX : c + 32'd1;
	endfunction

endpackage

@@ sv/token_bucket_rate_limiter.sv @@
// Token bucket policer: refill by elapsed time, admit or reject each request.
// Depends on tbrl_pkg and token_bucket_rate_limiter_defines.svh.
//
// Channel   Direction  Width  Contents
// s_axis    in         96     request_cost, now_ns
// m_axis    out        104    allowed, tokens_left, accepted_total, rejected_total
// cfg       in         64     register write, index 0..2
//
// A request whose time has advanced goes through two passes of the shared 32x32 multiplier,
// a saturation check, a multiply by the reciprocal of 1e9, a multiply back and up to four
// correcting subtractions. A saturated refill skips the division, a zero-cost request or
// one with no time advance skips the refill; s_tready returns with the result. Reset (arst_n
// low) fills the bucket to capacity and clears the counters. A stalled output holds the
// next result in its decision step; a request is still taken while the last waits.
`include "token_bucket_rate_limiter_defines.svh"

module token_bucket_rate_limiter (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // [31:0] request_cost, [95:32] now_ns
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // [0] allowed, [32:1] tokens_left,
	                                // [64:33] accepted_total, [96:65] rejected_total,
	                                // [103:97] zero
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import tbrl_pkg::*;

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_MUL0   = 4'd2;
	localparam logic [3:0] S_MUL1   = 4'd3;
	localparam logic [3:0] S_ADD    = 4'd4;
	localparam logic [3:0] S_SAT    = 4'd5;
	localparam logic [3:0] S_RECIP  = 4'd6;
	localparam logic [3:0] S_BACK   = 4'd7;
	localparam logic [3:0] S_REM    = 4'd8;
	localparam logic [3:0] S_FIX    = 4'd9;
	localparam logic [3:0] S_REFILL = 4'd10;
	localparam logic [3:0] S_DECIDE = 4'd11;

	logic [3:0]  state_q;
	logic [31:0] cap_q, rate_q;
	logic [63:0] start_q;
	logic [31:0] level_q;
	logic [63:0] last_q;
	logic [31:0] acc_q, rej_q;
	logic [31:0] cost_q;
	logic [63:0] now_q;
	logic [63:0] elapsed_q;
	logic [63:0] mul_q;
	logic [63:0] p_q;
	logic [63:0] rem_q;
	logic [31:0] quo_q;
	logic        out_valid_q;
	result_t     out_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [63:0] sub_a, sub_b;
	logic [64:0] diff;
	logic        borrow;
	logic [32:0] refill_sum;
	logic        out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q};
	assign out_free = !out_valid_q || m_tready;

	// Shared multiplier: the two halves of elapsed time times rate, then the reciprocal
	// estimate of the quotient, then the estimate times the divisor.
	always_comb begin
		case (state_q)
			S_MUL1: begin
				mul_a = elapsed_q[63:32];
				mul_b = rate_q;
			end
			S_RECIP: begin
				mul_a = {rem_q[29:0], p_q[31:30]};
				mul_b = NS_RECIP;
			end
			S_BACK: begin
				mul_a = quo_q;
				mul_b = NS_PER_SEC[31:0];
			end
			default: begin
				mul_a = elapsed_q[31:0];
				mul_b = rate_q;
			end
		endcase
	end

	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	// Shared subtractor, operands chosen by the sequencer.
	always_comb begin
		case (state_q)
			S_CHECK: begin
				sub_a = now_q;
				sub_b = last_q;
			end
			S_SAT, S_FIX: begin
				sub_a = rem_q;
				sub_b = NS_PER_SEC;
			end
			S_REM: begin
				sub_a = {2'd0, rem_q[29:0], p_q[31:0]};
				sub_b = mul_q;
			end
			S_DECIDE: begin
				sub_a = {32'd0, level_q};
				sub_b = {32'd0, cost_q};
			end
			default: begin
				sub_a = 64'd0;
				sub_b = 64'd0;
			end
		endcase
	end

	assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow = diff[64];

	// Refill sum before the clamp to capacity.
	assign refill_sum = {1'b0, level_q} + {1'b0, quo_q};

	// Sequencer, datapath registers and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CAPACITY_RST;
			rate_q      <= RATE_RST;
			start_q     <= START_RST;
			level_q     <= CAPACITY_RST;
			last_q      <= START_RST;
			acc_q       <= 32'd0;
			rej_q       <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			// In the decision step a completed transaction is followed by the next result.
			if (m_tvalid && m_tready && state_q != S_DECIDE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cost_q  <= s_tdata[31:0];
						now_q   <= s_tdata[95:32];
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					// Refill only for a nonzero cost with time moved forward.
					if (cost_q != 32'd0 && !borrow && diff[63:0] != 64'd0) begin
						elapsed_q <= diff[63:0];
						last_q    <= now_q;
						state_q   <= S_MUL0;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_MUL0: begin
					mul_q   <= mul_p;
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					p_q     <= mul_q;
					mul_q   <= mul_p;
					state_q <= S_ADD;
				end
				S_ADD: begin
					// Upper 64 bits of the 96-bit product.
					rem_q   <= mul_q + {32'd0, p_q[63:32]};
					state_q <= S_SAT;
				end
				S_SAT: begin
					// A quotient of 2^32 or more saturates the refill; otherwise the
					// product is below 2^62.
					if (!borrow) begin
						quo_q   <= 32'hFFFF_FFFF;
						state_q <= S_REFILL;
					end else begin
						state_q <= S_RECIP;
					end
				end
				S_RECIP: begin
					// Quotient estimate from the product's top 32 bits.
					quo_q   <= mul_p[62:31];
					state_q <= S_BACK;
				end
				S_BACK: begin
					mul_q   <= mul_p;
					state_q <= S_REM;
				end
				S_REM: begin
					// Remainder left by the estimate, below five times the divisor.
					rem_q   <= diff[63:0];
					state_q <= S_FIX;
				end
				S_FIX: begin
					// Take the divisor out until the remainder falls below it.
					if (!borrow) begin
						rem_q <= diff[63:0];
						quo_q <= quo_q + 32'd1;
					end else begin
						state_q <= S_REFILL;
					end
				end
				S_REFILL: begin
					if (refill_sum > {1'b0, cap_q}) begin
						level_q <= cap_q;
					end else begin
						level_q <= refill_sum[31:0];
					end
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					// Wait here until the output register is free.
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (cost_q == 32'd0) begin
							out_q <= '{rejected_total: rej_q, accepted_total: acc_q,
								tokens_left: level_q, allowed: 1'b0};
						end else if (!borrow) begin
							level_q <= diff[31:0];
							acc_q   <= count_up(acc_q);
							out_q   <= '{rejected_total: rej_q,
								accepted_total: count_up(acc_q),
								tokens_left: diff[31:0], allowed: 1'b1};
						end else begin
							rej_q <= count_up(rej_q);
							out_q <= '{rejected_total: count_up(rej_q),
								accepted_total: acc_q,
								tokens_left: level_q, allowed: 1'b0};
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// A register write refills the bucket and reloads the refill time.
			if (cfg_we) begin
				case (cfg_index)
					REG_CAPACITY: begin
						cap_q   <= cfg_data[31:0];
						level_q <= cfg_data[31:0];
						last_q  <= start_q;
					end
					REG_RATE: begin
						rate_q  <= cfg_data[31:0];
						level_q <= cap_q;
						last_q  <= start_q;
					end
					REG_START: begin
						start_q <= cfg_data;
						level_q <= cap_q;
						last_q  <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// The bucket never holds more than its capacity.
	`TBRL_ASSERT_ALWAYS(a_level_le_cap, level_q <= cap_q, "bucket level above capacity")
	// Every correction step starts from a remainder below five times the divisor.
	`TBRL_ASSERT(a_fix_rem, state_q == S_FIX |-> rem_q < NS_PER_SEC * 64'd5, "remainder too big")
	// An admitted result always reports a nonzero accepted count.
	`TBRL_ASSERT(a_allowed_count, out_valid_q && out_q.allowed |-> out_q.accepted_total != 32'd0, "admitted with zero count")

endmodule

@@ bench/token_bucket_rate_limiter_tb.sv @@
// Self-checking testbench for the token bucket rate limiter.
// Depends on tbrl_pkg and the token_bucket_rate_limiter RTL; it reads nothing else.
// Each request is predicted by a bit-accurate model of the bucket and every result is checked in order.
`timescale 1ns / 1ps

module token_bucket_rate_limiter_tb;
	import tbrl_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 55;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// Bucket model: configuration, state and the decisions still owed by the block.
	class bucket_ledger;
		logic [31:0] capacity;
		logic [31:0] rate;
		logic [63:0] start_ns;
		logic [31:0] level;
		logic [63:0] last_ns;
		logic [31:0] admitted;
		logic [31:0] refused;
		result_t     owed_decisions[$];
		int          errors;

		function void restart();
			capacity = CAPACITY_RST;
			rate     = RATE_RST;
			start_ns = START_RST;
			admitted = '0;
			refused  = '0;
			level    = capacity;
			last_ns  = start_ns;
			errors   = 0;
			owed_decisions.delete();
		endfunction

		// A register write refills the bucket and reloads the start time.
		function void write_reg(logic [1:0] idx, logic [63:0] data);
			case (idx)
				REG_CAPACITY: capacity = data[31:0];
				REG_RATE:     rate     = data[31:0];
				REG_START:    start_ns = data;
				default:      return;
			endcase
			level   = capacity;
			last_ns = start_ns;
		endfunction

		// Tokens earned over an elapsed time, truncated and saturated to 32 bits.
		function logic [31:0] tokens_earned(logic [63:0] elapsed);
			logic [63:0] secs;
			logic [63:0] rem;
			logic [63:0] sum;
			secs = elapsed / NS_PER_SEC;
			rem  = elapsed % NS_PER_SEC;
			if (rate == 32'd0)
				return 32'd0;
			if (secs > 64'hFFFF_FFFF)
				return '1;
			sum = secs * {32'd0, rate} + (rem * {32'd0, rate}) / NS_PER_SEC;
			if (sum > 64'hFFFF_FFFF)
				return '1;
			return sum[31:0];
		endfunction

		function logic [31:0] bump(logic [31:0] c);
			return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
		endfunction

		// Works out the decision for one accepted request and queues it.
		function void admit_request(logic [31:0] cost, logic [63:0] now);
			logic [32:0] topped;
			result_t     r;
			r.allowed = 1'b0;
			if (cost != 32'd0) begin
				if (now > last_ns) begin
					topped = {1'b0, level} + {1'b0, tokens_earned(now - last_ns)};
					if (topped > {1'b0, capacity})
						topped = {1'b0, capacity};
					level   = topped[31:0];
					last_ns = now;
				end
				if (level >= cost) begin
					level     = level - cost;
					admitted  = bump(admitted);
					r.allowed = 1'b1;
				end else begin
					refused = bump(refused);
				end
			end
			r.tokens_left    = level;
			r.accepted_total = admitted;
			r.rejected_total = refused;
			owed_decisions.push_back(r);
		endfunction

		// Compares one result transaction with the oldest owed decision.
		function void check_decision(result_t got);
			result_t want;
			if (owed_decisions.size() == 0) begin
				$error("unexpected result: allowed %0d tokens_left %0h", got.allowed,
					got.tokens_left);
				errors++;
				return;
			end
			want = owed_decisions.pop_front();
			if (got.allowed !== want.allowed) begin
				$error("allowed: expected %0d, actual %0d", want.allowed, got.allowed);
				errors++;
			end
			if (got.tokens_left !== want.tokens_left) begin
				$error("tokens_left: expected %0h, actual %0h", want.tokens_left,
					got.tokens_left);
				errors++;
			end
			if (got.accepted_total !== want.accepted_total) begin
				$error("accepted_total: expected %0d, actual %0d", want.accepted_total,
					got.accepted_total);
				errors++;
			end
			if (got.rejected_total !== want.rejected_total) begin
				$error("rejected_total: expected %0d, actual %0d", want.rejected_total,
					got.rejected_total);
				errors++;
			end
		endfunction

		function int outstanding();
			return owed_decisions.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [95:0]  s_tdata;   // [31:0] request_cost, [95:32] now_ns
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;   // [0] allowed, [32:1] tokens_left, [64:33] accepted_total,
	                         // [96:65] rejected_total, [103:97] zero
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [63:0]  cfg_data;

	bucket_ledger ledger;
	logic         no_idle;
	logic         hold_off_req;
	logic [63:0]  clock_ns;

	token_bucket_rate_limiter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (roll < 55)
			return 0;
		if (roll < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// Capacity or rate value drawn from a spread of magnitudes.
	function automatic logic [31:0] pick_level_value();
		case ($urandom_range(0, 5))
			0:       return $urandom;
			1:       return $urandom_range(1, 255);
			2:       return 32'd65536 << $urandom_range(0, 8);
			3:       return 32'hFFFF_FFFF;
			4:       return $urandom_range(1, 32'h000F_FFFF);
			default: return 32'd65536 * $urandom_range(1, 64);
		endcase
	endfunction

	// Offers one request and waits for its transaction, then idles at random.
	task automatic offer_request(input logic [31:0] cost, input logic [63:0] now);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {now, cost};
		do @(posedge clk); while (!s_tready);
		ledger.admit_request(cost, now);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Writes a register once the block has delivered everything and settled.
	task automatic write_config(input logic [1:0] idx, input logic [63:0] data);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (ledger.outstanding() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		ledger.write_reg(idx, data);
	endtask

	// Picks a fresh configuration; the start time is always reloaded.
	task automatic choose_setting(input int phase);
		logic [31:0] cap_v;
		logic [31:0] rate_v;
		logic [63:0] start_v;
		cap_v  = pick_level_value();
		rate_v = pick_level_value();
		if ($urandom_range(0, 9) == 0)
			rate_v = 32'd0;
		if ($urandom_range(0, 11) == 0)
			cap_v = 32'd0;
		if (phase == 1) begin
			cap_v  = '1;
			rate_v = '1;
		end
		start_v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} :
			{24'd0, 8'($urandom), $urandom};
		if (phase < 2 || $urandom_range(0, 2) != 0)
			write_config(REG_CAPACITY, {$urandom, cap_v});
		if (phase < 2 || $urandom_range(0, 2) != 0)
			write_config(REG_RATE, {$urandom, rate_v});
		if ($urandom_range(0, 7) == 0)
			write_config(REG_UNUSED, {$urandom, $urandom});
		write_config(REG_START, start_v);
		clock_ns = ledger.last_ns;
	endtask

	// Random requests with costs scaled to the bucket and times scaled to the refill.
	task automatic run_phase(input int count, input bit pressure);
		logic [31:0] cost;
		logic [31:0] span;
		logic [63:0] now;
		logic [63:0] typical;
		int          roll;
		span = (ledger.capacity == 32'd0) ? 32'd65536 : ledger.capacity;
		if (ledger.rate == 32'd0)
			typical = NS_PER_SEC;
		else
			typical = ({32'd0, ledger.capacity} * NS_PER_SEC) / {32'd0, ledger.rate} / 4;
		if (pressure) begin
			no_idle      = 1'b1;
			hold_off_req = 1'b1;
		end
		for (int i = 0; i < count; i++) begin
			if (pressure && i == 30)
				no_idle = 1'b0;
			roll = $urandom_range(0, 99);
			if (roll < 5)
				cost = 32'd0;
			else if (roll < 10)
				cost = $urandom;
			else if (roll < 14)
				cost = ledger.capacity;
			else
				cost = (($urandom % span) + 32'd1) >> $urandom_range(0, 2);
			roll = $urandom_range(0, 99);
			if (roll < 5)
				now = clock_ns;
			else if (roll < 8)
				now = clock_ns - {32'd0, $urandom};
			else if (roll < 11)
				now = {$urandom, $urandom};
			else if (roll < 13)
				now = clock_ns + {24'd0, 8'($urandom), $urandom};
			else if (typical < 64)
				now = clock_ns + $urandom_range(0, 128);
			else
				now = clock_ns + (typical >> 6) * $urandom_range(0, 128);
			clock_ns = now;
			offer_request(cost, now);
		end
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : result_sink
		int stall;
		stall    = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				ledger.check_decision(result_t'(m_tdata[96:0]));
			@(negedge clk);
			if (hold_off_req) begin
				stall        = HOLD_CYCLES;
				hold_off_req = 1'b0;
			end else if (stall == 0 && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Guard against a hung block.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("token_bucket_rate_limiter test failed");
		$finish;
	end

	// Reset, directed cases, random phases, then drain and report.
	initial begin : stimulus
		ledger = new();
		ledger.restart();
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_CAPACITY;
		cfg_data     = '0;
		no_idle      = 1'b0;
		hold_off_req = 1'b0;
		clock_ns     = '0;
		arst_n       = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset setting: zero cost, exact fill, refill on advance, time going back,
		// and a refill large enough to saturate.
		offer_request(32'd0, 64'd0);
		offer_request(32'h0001_0000, 64'd0);
		offer_request(32'd1, 64'd0);
		offer_request(32'h0000_8000, 64'd500_000_000);
		offer_request(32'd1, 64'd400_000_000);
		offer_request(32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		offer_request(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		offer_request(32'h0001_0000, 64'hFFFF_FFFF_FFFF_FFFF);

		// Largest capacity and rate.
		write_config(REG_CAPACITY, {32'hA5A5_5A5A, 32'hFFFF_FFFF});
		write_config(REG_RATE, {32'h5A5A_A5A5, 32'hFFFF_FFFF});
		write_config(REG_START, 64'd0);
		offer_request(32'hFFFF_FFFF, 64'd0);
		offer_request(32'd1, 64'd1);
		offer_request(32'd2, 64'd999_999_999);
		offer_request(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);

		// Zero rate gives no refill at all.
		write_config(REG_RATE, 64'd0);
		offer_request(32'hFFFF_FFFF, 64'd1_000_000_000_000);
		offer_request(32'd1, 64'd2_000_000_000_000);

		// Latest possible start time: no request can advance past it.
		write_config(REG_START, 64'hFFFF_FFFF_FFFF_FFFF);
		offer_request(32'hFFFF_FFFF, 64'd5);
		offer_request(32'd1, 64'd6);

		// Empty bucket, and a write to an index with no register behind it.
		write_config(REG_CAPACITY, 64'd0);
		offer_request(32'd1, 64'd7);
		offer_request(32'd0, 64'd8);
		write_config(REG_UNUSED, {$urandom, $urandom});
		offer_request(32'h8000_0000, 64'd0);

		// Slowest rate: the truncated fraction of a token is lost.
		write_config(REG_CAPACITY, 64'd65536);
		write_config(REG_RATE, 64'd1);
		write_config(REG_START, 64'd0);
		offer_request(32'h0001_0000, 64'd0);
		offer_request(32'd1, 64'd1_000_000_000);
		offer_request(32'd1, 64'd1_999_999_999);

		for (int p = 0; p < PHASES; p++) begin
			choose_setting(p);
			run_phase(PHASE_ITEMS, p == 3);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (ledger.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.errors == 0)
			$display("token_bucket_rate_limiter test passed");
		else
			$display("token_bucket_rate_limiter test failed");
		$finish;
	end

endmodule
